FILE: rtl/touch_gesture_classifier_assert.svh
// assertion macros for the touch gesture classifier
`ifndef TOUCH_GESTURE_CLASSIFIER_ASSERT_SVH
`define TOUCH_GESTURE_CLASSIFIER_ASSERT_SVH

// property checked on every clock edge outside reset
`define TGC_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("tgc assertion failed");

// implication checked on every clock edge outside reset
`define TGC_ASSERT_IMP(label, cond, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error("tgc implication failed");

`endif

FILE: rtl/tgc_pkg.sv
// shared types and constants for the touch gesture classifier
`timescale 1ns / 1ps
package tgc_pkg;

    localparam int DIV_BITS    = 13;
    localparam int IDIV_STEPS  = 16;
    localparam int CNT_BITS    = 4;
    localparam int COORD_BITS  = 12;

    typedef enum logic [3:0] {
        EV_ACTION    = 4'd0,
        EV_BACK      = 4'd1,
        EV_MIC       = 4'd2,
        EV_SECONDARY = 4'd3,
        EV_PRIMARY   = 4'd4,
        EV_UP        = 4'd5,
        EV_DOWN      = 4'd6,
        EV_LEFT      = 4'd7,
        EV_RIGHT     = 4'd8
    } t_event;

    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_RIGHT = 2'd3
    } t_dir;

    typedef enum logic [2:0] {
        REG_ACTION_COUNT  = 3'd0,
        REG_TOUCHBAR_TOP  = 3'd1,
        REG_SYSTEM_ROW    = 3'd2,
        REG_CENTER_X      = 3'd3,
        REG_CENTER_Y      = 3'd4,
        REG_RADIUS_SQ     = 3'd5,
        REG_LONG_PRESS    = 3'd6,
        REG_DIR_MIN       = 3'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WDIV,
        S_IDIV,
        S_MULX,
        S_MULY,
        S_DECIDE
    } t_state;

    typedef struct packed {
        logic [3:0]  btn_count;
        logic [11:0] bar_top;
        logic [11:0] row_top;
        logic [11:0] center_x;
        logic [11:0] center_y;
        logic [24:0] center_radius_sq;
        logic [15:0] hold_ms;
        logic [11:0] direction_min_pixels;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic wdiv_step;
        logic idiv_step;
        logic mul_x;
        logic mul_y;
        logic decide;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
    } t_dp_stat;

    function automatic logic [11:0] mag13(input logic signed [12:0] v);
        logic signed [12:0] a;
        a = (v < 0) ? -v : v;
        return a[11:0];
    endfunction

    function automatic t_event dir_event(input t_dir d);
        t_event e;
        case (d)
            DIR_UP:    e = EV_UP;
            DIR_DOWN:  e = EV_DOWN;
            DIR_LEFT:  e = EV_LEFT;
            DIR_RIGHT: e = EV_RIGHT;
            default:   e = EV_UP;
        endcase
        return e;
    endfunction

endpackage

FILE: rtl/tgc_regs.sv
// configuration register file with apb-style access
`timescale 1ns / 1ps
module tgc_regs import tgc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);
    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr;

    assign idx    = t_reg_idx'(paddr[4:2]);
    assign wr     = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.btn_count            <= 4'd0;
            r_cfg.bar_top              <= 12'd3584;
            r_cfg.row_top              <= 12'd3072;
            r_cfg.center_x             <= 12'd2048;
            r_cfg.center_y             <= 12'd1536;
            r_cfg.center_radius_sq     <= 25'd65536;
            r_cfg.hold_ms              <= 16'd500;
            r_cfg.direction_min_pixels <= 12'd40;
        end else if (wr) begin
            case (idx)
                REG_ACTION_COUNT: r_cfg.btn_count            <= pwdata[3:0];
                REG_TOUCHBAR_TOP: r_cfg.bar_top              <= pwdata[11:0];
                REG_SYSTEM_ROW:   r_cfg.row_top              <= pwdata[11:0];
                REG_CENTER_X:     r_cfg.center_x             <= pwdata[11:0];
                REG_CENTER_Y:     r_cfg.center_y             <= pwdata[11:0];
                REG_RADIUS_SQ:    r_cfg.center_radius_sq     <= pwdata[24:0];
                REG_LONG_PRESS:   r_cfg.hold_ms              <= pwdata[15:0];
                REG_DIR_MIN:      r_cfg.direction_min_pixels <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_ACTION_COUNT: prdata = {28'd0, r_cfg.btn_count};
            REG_TOUCHBAR_TOP: prdata = {20'd0, r_cfg.bar_top};
            REG_SYSTEM_ROW:   prdata = {20'd0, r_cfg.row_top};
            REG_CENTER_X:     prdata = {20'd0, r_cfg.center_x};
            REG_CENTER_Y:     prdata = {20'd0, r_cfg.center_y};
            REG_RADIUS_SQ:    prdata = {7'd0, r_cfg.center_radius_sq};
            REG_LONG_PRESS:   prdata = {16'd0, r_cfg.hold_ms};
            REG_DIR_MIN:      prdata = {20'd0, r_cfg.direction_min_pixels};
            default:          prdata = 32'd0;
        endcase
    end
endmodule

FILE: rtl/tgc_ctrl.sv
// sequencing state machine for one sample
`timescale 1ns / 1ps
module tgc_ctrl import tgc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);
    t_state               r_state, n_state;
    logic [CNT_BITS-1:0]  r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (i_valid) n_state = S_WDIV;
            end
            S_WDIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(DIV_BITS - 1)) begin
                    n_state = S_IDIV;
                    n_cnt   = '0;
                end
            end
            S_IDIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(IDIV_STEPS - 1)) n_state = S_MULX;
            end
            S_MULX: n_state = S_MULY;
            S_MULY: n_state = S_DECIDE;
            S_DECIDE: begin
                if (!i_stat.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = (r_state != S_IDLE);
        case (r_state)
            S_IDLE:   o_cmd.load      = i_valid;
            S_WDIV:   o_cmd.wdiv_step = 1'b1;
            S_IDIV:   o_cmd.idiv_step = 1'b1;
            S_MULX:   o_cmd.mul_x     = 1'b1;
            S_MULY:   o_cmd.mul_y     = 1'b1;
            S_DECIDE: o_cmd.decide    = !i_stat.out_busy;
            default:  o_cmd           = '0;
        endcase
    end
endmodule

FILE: rtl/tgc_dp.sv
// datapath: divider, shared squarer, gesture state and result register
`timescale 1ns / 1ps
module tgc_dp import tgc_pkg::*; #(
    parameter int MAX_ACTIONS     = 8,
    parameter int BAR_START_X     = 0,
    parameter int BAR_WIDTH       = 1024,
    parameter int DIVIDER_X       = 512,
    parameter int REL_COUNT_MIN   = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    input  t_cfg        i_cfg,
    input  logic        i_command,
    input  logic [11:0] i_pos_x,
    input  logic [11:0] i_pos_y,
    input  logic [31:0] i_now_ms,
    input  logic        i_sink_accepts,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_event_code,
    output logic [2:0]  o_action_index
);
    `include "touch_gesture_classifier_assert.svh"

    localparam logic [11:0] CMASK = (COORD_BITS >= 12) ? 12'hFFF
                                                       : 12'((1 << COORD_BITS) - 1);
    localparam logic [11:0]         BSX  = 12'(BAR_START_X);
    localparam logic [11:0]         DVX  = 12'(DIVIDER_X);
    localparam logic [DIV_BITS-1:0] BW   = DIV_BITS'(BAR_WIDTH);
    localparam logic [4:0]          MAXN = 5'(MAX_ACTIONS);
    localparam logic [7:0]          RS   = 8'(REL_COUNT_MIN);

    // item words
    logic        r_cmd, r_ok;
    logic [11:0] r_x, r_y;
    logic [31:0] r_now;

    // gesture state
    logic        r_pad, r_await, r_rep, r_lpd;
    logic [11:0] r_ax, r_ay;
    logic [31:0] r_press;
    t_dir        r_dir;
    logic [7:0]  r_rc;

    // divider and squarer
    logic [DIV_BITS-1:0] r_wq;
    logic [4:0]          r_wrem;
    logic [DIV_BITS-1:0] r_rem;
    logic [3:0]          r_q;
    logic [25:0]         r_dist;

    // result register
    logic   r_out_valid;
    t_event r_ev;
    logic [2:0] r_idx;

    logic [4:0]          n_bar;
    logic [5:0]          wrem_sh;
    logic [5:0]          wrem_sub;
    logic                wge;
    logic [DIV_BITS-1:0] w_eff;
    logic [11:0]         xm;
    logic signed [12:0]  cdx, cdy, mop;
    logic signed [25:0]  prod;

    assign n_bar    = ({1'b0, i_cfg.btn_count} > MAXN) ? MAXN : {1'b0, i_cfg.btn_count};
    assign wrem_sh  = {r_wrem, r_wq[DIV_BITS-1]};
    assign wrem_sub = wrem_sh - {1'b0, n_bar};
    assign wge      = wrem_sh >= {1'b0, n_bar};
    assign w_eff    = (r_wq == '0) ? BW : r_wq;
    assign xm       = i_pos_x & CMASK;
    assign cdx      = $signed({1'b0, r_ax}) - $signed({1'b0, i_cfg.center_x});
    assign cdy      = $signed({1'b0, r_ay}) - $signed({1'b0, i_cfg.center_y});
    assign mop      = i_cmd.mul_y ? cdy : cdx;
    assign prod     = mop * mop;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= i_command;
            r_ok   <= i_sink_accepts;
            r_x    <= xm;
            r_y    <= i_pos_y & CMASK;
            r_now  <= i_now_ms;
            r_wq   <= BW;
            r_wrem <= '0;
            r_rem  <= (xm >= BSX) ? {1'b0, xm - BSX} : '0;
            r_q    <= '0;
        end
        if (i_cmd.wdiv_step) begin
            r_wrem <= wge ? wrem_sub[4:0] : wrem_sh[4:0];
            r_wq   <= {r_wq[DIV_BITS-2:0], wge};
        end
        // index saturates at the last button
        if (i_cmd.idiv_step && r_rem >= w_eff && ({1'b0, r_q} + 5'd1) < n_bar) begin
            r_rem <= r_rem - w_eff;
            r_q   <= r_q + 4'd1;
        end
        if (i_cmd.mul_x) r_dist <= prod[25:0];
        if (i_cmd.mul_y) r_dist <= r_dist + prod[25:0];
    end

    // decision logic
    logic               n_pad, n_await, n_rep, n_lpd, n_emit;
    logic [11:0]        n_ax, n_ay;
    logic [31:0]        n_press;
    t_dir               n_dir, d;
    logic [7:0]         n_rc, rc_inc;
    t_event             n_ev;
    logic [2:0]         n_idx;
    logic signed [12:0] ddx, ddy, step;
    logic [11:0]        mdx, mdy, cmx, cmy;
    logic [31:0]        hold;
    logic               in_center, horiz;

    assign ddx       = $signed({1'b0, r_x}) - $signed({1'b0, r_ax});
    assign ddy       = $signed({1'b0, r_y}) - $signed({1'b0, r_ay});
    assign mdx       = mag13(ddx);
    assign mdy       = mag13(ddy);
    assign cmx       = mag13(cdx);
    assign cmy       = mag13(cdy);
    assign hold      = r_now - r_press;
    assign in_center = r_dist <= {1'b0, i_cfg.center_radius_sq};
    assign horiz     = r_dir[1];
    assign step      = horiz ? ddx : ddy;
    assign rc_inc    = (r_rc == 8'hFF) ? r_rc : r_rc + 8'd1;

    always_comb begin
        n_pad   = r_pad;
        n_await = r_await;
        n_rep   = r_rep;
        n_lpd   = r_lpd;
        n_ax    = r_ax;
        n_ay    = r_ay;
        n_press = r_press;
        n_dir   = r_dir;
        n_rc    = r_rc;
        n_emit  = 1'b0;
        n_ev    = EV_ACTION;
        n_idx   = 3'd0;
        d       = DIR_UP;
        if (!r_cmd) begin
            n_rc = 8'd0;
            if (r_await) begin
                n_emit = 1'b0;
            end else if (r_y >= i_cfg.bar_top && !r_pad) begin
                if (n_bar != 5'd0) begin
                    n_emit = 1'b1;
                    n_idx  = r_q[2:0];
                    if (r_ok) n_await = 1'b1;
                end
            end else if (r_y >= i_cfg.row_top && !r_pad) begin
                n_emit = 1'b1;
                n_ev   = (r_x < DVX) ? EV_BACK : EV_MIC;
                if (r_ok) n_await = 1'b1;
            end else if (!r_pad) begin
                n_pad   = 1'b1;
                n_ax    = r_x;
                n_ay    = r_y;
                n_press = r_now;
            end else if (!r_rep && !r_lpd && hold >= {16'd0, i_cfg.hold_ms}
                         && in_center) begin
                n_emit = 1'b1;
                n_ev   = EV_SECONDARY;
                if (r_ok) n_lpd = 1'b1;
            end else if (r_rep) begin
                // locked axis repeat
                if (mag13(step) >= i_cfg.direction_min_pixels) begin
                    if (horiz) d = (step > 0) ? DIR_RIGHT : DIR_LEFT;
                    else       d = (step > 0) ? DIR_DOWN : DIR_UP;
                    n_emit = 1'b1;
                    n_ev   = dir_event(d);
                    if (r_ok) begin
                        n_ax  = r_x;
                        n_ay  = r_y;
                        n_dir = d;
                    end
                end
            end else if (mdx >= i_cfg.direction_min_pixels
                         || mdy >= i_cfg.direction_min_pixels) begin
                if (mdx >= mdy) d = (ddx > 0) ? DIR_RIGHT : DIR_LEFT;
                else            d = (ddy > 0) ? DIR_DOWN : DIR_UP;
                n_emit = 1'b1;
                n_ev   = dir_event(d);
                if (r_ok) begin
                    n_ax  = r_x;
                    n_ay  = r_y;
                    n_rep = 1'b1;
                    n_dir = d;
                end
            end
        end else begin
            n_rc = rc_inc;
            if (r_pad) begin
                n_pad   = 1'b0;
                n_await = 1'b1;
                n_lpd   = 1'b0;
                if (r_rep) begin
                    n_rep = 1'b0;
                end else if (!r_lpd) begin
                    // tap
                    n_emit = 1'b1;
                    if (in_center)       n_ev = EV_PRIMARY;
                    else if (cmx >= cmy) n_ev = (cdx > 0) ? EV_RIGHT : EV_LEFT;
                    else                 n_ev = (cdy > 0) ? EV_DOWN : EV_UP;
                end
            end else if (r_await && rc_inc >= RS) begin
                n_await = 1'b0;
                n_rc    = 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad       <= 1'b0;
            r_await     <= 1'b0;
            r_rep       <= 1'b0;
            r_lpd       <= 1'b0;
            r_ax        <= '0;
            r_ay        <= '0;
            r_press     <= '0;
            r_dir       <= DIR_UP;
            r_rc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.decide) begin
                r_pad       <= n_pad;
                r_await     <= n_await;
                r_rep       <= n_rep;
                r_lpd       <= n_lpd;
                r_ax        <= n_ax;
                r_ay        <= n_ay;
                r_press     <= n_press;
                r_dir       <= n_dir;
                r_rc        <= n_rc;
                r_out_valid <= n_emit;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide && n_emit) begin
            r_ev  <= n_ev;
            r_idx <= n_idx;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_event_code    = r_ev;
    assign o_action_index  = r_idx;
    assign o_stat.out_busy = r_out_valid & i_stall;

    `TGC_ASSERT(a_pad_await_excl, !(r_pad && r_await))
    `TGC_ASSERT_IMP(a_rep_needs_pad, r_rep, r_pad)
    `TGC_ASSERT_IMP(a_lpd_needs_pad, r_lpd, r_pad)
    `TGC_ASSERT_IMP(a_idx_only_action, r_out_valid && r_ev != EV_ACTION, r_idx == 3'd0)
endmodule

FILE: rtl/touch_gesture_classifier.sv
// touch gesture classifier top level
// an accepted sample runs through the 13-step width divider, the 16-step button index
// search, two passes through the shared squarer and a decision that waits while output
// stalls; the decision registers the event word, and a new sample is taken only in idle
// a sample that gives no event still occupies the full sequence
// reset: synchronous active low, clears gesture state and loads register defaults
`timescale 1ns / 1ps
module touch_gesture_classifier import tgc_pkg::*; #(
    parameter int MAX_ACTIONS     = 8,
    parameter int BAR_START_X     = 0,
    parameter int BAR_WIDTH       = 1024,
    parameter int DIVIDER_X       = 512,
    parameter int REL_COUNT_MIN   = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [11:0] i_pos_x,
    input  logic [11:0] i_pos_y,
    input  logic [31:0] i_now_ms,
    input  logic        i_sink_accepts,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_event_code,
    output logic [2:0]  o_action_index
);
    t_cfg     cfg;
    t_dp_cmd  cmd;
    t_dp_stat stat;

    tgc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tgc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    tgc_dp #(
        .MAX_ACTIONS     (MAX_ACTIONS),
        .BAR_START_X     (BAR_START_X),
        .BAR_WIDTH       (BAR_WIDTH),
        .DIVIDER_X       (DIVIDER_X),
        .REL_COUNT_MIN   (REL_COUNT_MIN)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg          (cfg),
        .i_command      (i_command),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_now_ms       (i_now_ms),
        .i_sink_accepts (i_sink_accepts),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_event_code   (o_event_code),
        .o_action_index (o_action_index)
    );
endmodule
